// ===== sv/adpcmd_pkg.sv =====
// ----------------------------------------------------------------------------
// adpcmd_pkg
// Shared types, register codes and tables for the ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package adpcmd_pkg;

  localparam int unsigned StepMax   = 48;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned PredW     = 12;
  localparam int unsigned StepW     = 11;
  localparam int unsigned MagW      = 12;

  localparam logic OpRead    = 1'b0;
  localparam logic OpWrite   = 1'b1;
  localparam logic RegCmd    = 1'b0;
  localparam logic RegData   = 1'b1;

  localparam int unsigned CmdStopBit  = 0;
  localparam int unsigned CmdStartBit = 1;

  localparam logic [7:0] StatusPlaying = 8'hC0;
  localparam logic [7:0] StatusIdle    = 8'h40;

  localparam logic signed [PredW-1:0] PredMax = 12'sd2047;
  localparam logic signed [PredW-1:0] PredMin = -12'sd2048;

  typedef struct packed {
    logic [IdxW-1:0]         step_index;
    logic signed [PredW-1:0] predictor;
  } adpcmd_state_t;

  function automatic logic [StepW-1:0] step_size(input logic [IdxW-1:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;   6'd3:  s = 11'd21;
      6'd4:  s = 11'd23;   6'd5:  s = 11'd25;   6'd6:  s = 11'd28;   6'd7:  s = 11'd31;
      6'd8:  s = 11'd34;   6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;   6'd15: s = 11'd66;
      6'd16: s = 11'd73;   6'd17: s = 11'd80;   6'd18: s = 11'd88;   6'd19: s = 11'd97;
      6'd20: s = 11'd107;  6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;  6'd27: s = 11'd209;
      6'd28: s = 11'd230;  6'd29: s = 11'd253;  6'd30: s = 11'd279;  6'd31: s = 11'd307;
      6'd32: s = 11'd337;  6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;  6'd39: s = 11'd658;
      6'd40: s = 11'd724;  6'd41: s = 11'd796;  6'd42: s = 11'd876;  6'd43: s = 11'd963;
      6'd44: s = 11'd1060; 6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      default: s = 11'd1552;
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_move(input logic [2:0] code);
    logic signed [4:0] m;
    case (code)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/adpcmd_if.sv =====
// ----------------------------------------------------------------------------
// adpcmd_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface adpcmd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       reg_select;
  logic [7:0] write_byte;

  modport source (output valid, op, reg_select, write_byte, input ready);
  modport sink   (input valid, op, reg_select, write_byte, output ready);
endinterface

interface adpcmd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic              samples_valid;
  logic signed [11:0] first_sample;
  logic signed [11:0] second_sample;

  modport source (output valid, read_data, samples_valid, first_sample, second_sample,
                  input ready);
  modport sink   (input valid, read_data, samples_valid, first_sample, second_sample,
                  output ready);
endinterface

// ===== sv/adpcm_nibble_decoder_top.sv =====
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder_top
// Register-mapped 4-bit ADPCM decoder with valid/ready bus channels.
// ----------------------------------------------------------------------------
// Every bus access is one input transaction and returns exactly one result
// transaction. The block accepts one access per clock while results are taken;
// a result appears when the result register loads it from the input register.
// The decode path between those registers is combinational: both nibbles of
// a data byte go through two chained step-table lookups, adds and clamps.
// A full result register that is not taken stalls the input.
// ----------------------------------------------------------------------------
module adpcm_nibble_decoder_top import adpcmd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  adpcmd_in_if.sink      in_i,
  adpcmd_out_if.source   out_o
);

  logic              s1_valid_q;
  logic              s1_op_q;
  logic              s1_reg_q;
  logic [7:0]        s1_byte_q;

  logic              out_valid_q;
  logic [7:0]        rd_data_q;
  logic              smp_valid_q;
  logic signed [PredW-1:0] first_q;
  logic signed [PredW-1:0] second_q;

  adpcmd_state_t     dec_q, dec_d;
  logic              playing_q, playing_d;

  adpcmd_state_t     mid_state;
  adpcmd_state_t     end_state;

  logic              advance;
  logic              decode;
  logic [7:0]        rd_data_d;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  adpcmd_nibble u_low (
    .state_i  (dec_q),
    .nibble_i (s1_byte_q[3:0]),
    .state_o  (mid_state)
  );

  adpcmd_nibble u_high (
    .state_i  (mid_state),
    .nibble_i (s1_byte_q[7:4]),
    .state_o  (end_state)
  );

  assign decode = (s1_op_q == OpWrite) && (s1_reg_q == RegData) && playing_q;

  always_comb begin
    rd_data_d = '0;
    if ((s1_op_q == OpRead) && (s1_reg_q == RegCmd)) begin
      rd_data_d = playing_q ? StatusPlaying : StatusIdle;
    end
  end

  always_comb begin
    dec_d     = dec_q;
    playing_d = playing_q;
    if ((s1_op_q == OpWrite) && (s1_reg_q == RegCmd)) begin
      if (s1_byte_q[CmdStopBit]) begin
        playing_d = 1'b0;
      end else if (s1_byte_q[CmdStartBit] && !playing_q) begin
        dec_d     = '0;
        playing_d = 1'b1;
      end
    end else if (decode) begin
      dec_d = end_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dec_q       <= '0;
      playing_q   <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        dec_q       <= dec_d;
        playing_q   <= playing_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.op;
      s1_reg_q  <= in_i.reg_select;
      s1_byte_q <= in_i.write_byte;
    end
    if (advance) begin
      rd_data_q   <= rd_data_d;
      smp_valid_q <= decode;
      first_q     <= decode ? mid_state.predictor : '0;
      second_q    <= decode ? end_state.predictor : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = rd_data_q;
  assign out_o.samples_valid = smp_valid_q;
  assign out_o.first_sample  = first_q;
  assign out_o.second_sample = second_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_q.step_index <= IdxW'(StepMax))
    else $error("step index left its range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_op_q == OpWrite) && (s1_reg_q == RegCmd) && s1_byte_q[CmdStopBit]
    |=> !playing_q)
    else $error("stop command did not halt playback");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_op_q == OpWrite) && (s1_reg_q == RegData) && !playing_q
    |=> $stable(dec_q))
    else $error("data write while stopped changed decoder state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.samples_valid
    |-> (out_o.first_sample == '0) && (out_o.second_sample == '0))
    else $error("samples driven on a transaction without decode");

endmodule

// ===== sv/adpcmd_nibble.sv =====
// ----------------------------------------------------------------------------
// adpcmd_nibble
// Decodes one 4-bit code: predictor update with saturation and step index
// adaptation with clamping.
// ----------------------------------------------------------------------------
module adpcmd_nibble import adpcmd_pkg::*; (
  input  adpcmd_state_t state_i,
  input  logic [3:0]    nibble_i,
  output adpcmd_state_t state_o
);

  logic [StepW-1:0]      step;
  logic [14:0]           prod;
  logic [MagW-1:0]       mag;
  logic signed [13:0]    pred_sum;
  logic signed [7:0]     idx_sum;

  assign step = step_size(state_i.step_index);
  assign prod = 15'(step) * 15'({nibble_i[2:0], 1'b1});
  assign mag  = prod[14:3];

  always_comb begin
    if (nibble_i[3]) begin
      pred_sum = 14'(state_i.predictor) - $signed({2'b00, mag});
    end else begin
      pred_sum = 14'(state_i.predictor) + $signed({2'b00, mag});
    end
    if (pred_sum > 14'(PredMax)) begin
      state_o.predictor = PredMax;
    end else if (pred_sum < 14'(PredMin)) begin
      state_o.predictor = PredMin;
    end else begin
      state_o.predictor = pred_sum[PredW-1:0];
    end
  end

  always_comb begin
    idx_sum = $signed({2'b00, state_i.step_index}) + 8'(index_move(nibble_i[2:0]));
    if (idx_sum < 8'sd0) begin
      state_o.step_index = '0;
    end else if (idx_sum > 8'(StepMax)) begin
      state_o.step_index = IdxW'(StepMax);
    end else begin
      state_o.step_index = idx_sum[IdxW-1:0];
    end
  end

endmodule
